// ===== rtl/pfoc_pkg.sv =====
// Shared types and constants for the presence fusion on/off controller.
package pfoc_pkg;

  localparam int unsigned LIGHT_MAX = 65535;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 16;

  // Configuration register indexes.
  localparam logic [CfgIndexWidth-1:0] REG_EDGE_MASK   = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_KEEP_MASK   = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_ONOFF_MODE  = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_ONOFF_TMO   = 3'd3;
  localparam logic [CfgIndexWidth-1:0] REG_LIGHT_THRES = 3'd4;

  // On/off modes.
  localparam logic [2:0] MODE_NOTHING     = 3'd0;
  localparam logic [2:0] MODE_ON_OFF      = 3'd1;
  localparam logic [2:0] MODE_ON_ONLY     = 3'd2;
  localparam logic [2:0] MODE_OFF_ONLY    = 3'd3;
  localparam logic [2:0] MODE_TIMED_ON    = 3'd4;
  localparam logic [2:0] MODE_TIMED_LOCAL = 3'd5;

  // Command codes.
  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_ON    = 2'd1;
  localparam logic [1:0] CMD_OFF   = 2'd2;
  localparam logic [1:0] CMD_TIMED = 2'd3;

  // Operation codes.
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef struct packed {
    logic        operation;
    logic        mmwave_present;
    logic        pir_present;
    logic        external_present;
    logic [15:0] illuminance;
    logic        targets_bound;
  } in_item_t;

  typedef struct packed {
    logic        presence;
    logic        presence_toggle;
    logic [1:0]  command;
    logic        suppressed;
    logic [15:0] false_pir_count;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  edge_mask;
    logic [2:0]  keep_mask;
    logic [2:0]  onoff_mode;
    logic [15:0] onoff_timeout;
    logic [15:0] illuminance_threshold;
  } cfg_t;

endpackage

// ===== rtl/pfoc_cfg_regs.sv =====
// Configuration register file for the presence fusion on/off controller.
module pfoc_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [pfoc_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  logic [pfoc_pkg::CfgDataWidth-1:0]    cfg_data,
  output pfoc_pkg::cfg_t                       cfg
);
  import pfoc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.edge_mask             <= 3'd1;
      cfg.keep_mask             <= 3'd1;
      cfg.onoff_mode            <= MODE_ON_OFF;
      cfg.onoff_timeout         <= 16'd0;
      cfg.illuminance_threshold <= 16'hFFFF;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EDGE_MASK:   cfg.edge_mask             <= cfg_data[2:0];
        REG_KEEP_MASK:   cfg.keep_mask             <= cfg_data[2:0];
        REG_ONOFF_MODE:  cfg.onoff_mode            <= cfg_data[2:0];
        REG_ONOFF_TMO:   cfg.onoff_timeout         <= cfg_data[15:0];
        REG_LIGHT_THRES: cfg.illuminance_threshold <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/pfoc_fusion.sv =====
// Fusion state registers and the single-pass next-state and result logic.
module pfoc_fusion (
  input  logic                 clk,
  input  logic                 rst,
  input  pfoc_pkg::cfg_t       cfg,
  input  logic                 fire,
  input  pfoc_pkg::in_item_t   item,
  output pfoc_pkg::out_item_t  result
);
  import pfoc_pkg::*;

  logic        fused_presence, first_update, retrigger_allowed;
  logic        last_radar, last_pir, suppress_flag, pir_probe, timer_active;
  logic [15:0] false_pulses, timer_left;

  logic        fused_presence_next, first_update_next, retrigger_allowed_next;
  logic        last_radar_next, last_pir_next, suppress_flag_next, pir_probe_next;
  logic        timer_active_next;
  logic [15:0] false_pulses_next, timer_left_next;

  logic        changed, trig, on_cmd, mode_valid, cmd_blocked;
  logic [1:0]  cmd;
  logic [2:0]  srcs;

  always_comb begin
    fused_presence_next    = fused_presence;
    first_update_next      = first_update;
    retrigger_allowed_next = retrigger_allowed;
    last_radar_next        = last_radar;
    last_pir_next          = last_pir;
    suppress_flag_next     = suppress_flag;
    pir_probe_next         = pir_probe;
    timer_active_next      = timer_active;
    false_pulses_next      = false_pulses;
    timer_left_next        = timer_left;
    changed                = 1'b0;
    trig                   = 1'b0;
    cmd                    = CMD_NONE;
    srcs                   = {item.external_present, item.pir_present, item.mmwave_present};
    on_cmd                 = 1'b0;
    mode_valid             = 1'b0;
    cmd_blocked            = 1'b0;

    if (item.operation == OP_TICK) begin
      if (timer_active) begin
        if (timer_left > 16'd1) begin
          timer_left_next = timer_left - 16'd1;
        end else begin
          timer_left_next = 16'd0;
          if (fused_presence) begin
            if (cfg.onoff_timeout != 16'd0) begin
              timer_left_next = cfg.onoff_timeout;
            end else begin
              timer_active_next = 1'b0;
            end
          end else begin
            timer_active_next = 1'b0;
            if (item.targets_bound) begin
              cmd = CMD_OFF;
            end
          end
        end
      end
    end else begin
      // A PIR pulse that starts and ends without radar counts as false.
      if (item.pir_present && !last_pir) begin
        if (!item.mmwave_present) begin
          pir_probe_next = 1'b1;
        end
      end else if (!item.pir_present && last_pir) begin
        if (pir_probe && !item.mmwave_present) begin
          pir_probe_next = 1'b0;
          if (false_pulses != 16'hFFFF) begin
            false_pulses_next = false_pulses + 16'd1;
          end
        end
      end
      if (item.mmwave_present) begin
        pir_probe_next = 1'b0;
      end
      last_radar_next = item.mmwave_present;
      last_pir_next   = item.pir_present;

      if (first_update || retrigger_allowed || !fused_presence) begin
        trig = |(cfg.edge_mask & srcs);
        if (trig) begin
          fused_presence_next    = 1'b1;
          retrigger_allowed_next = 1'b0;
        end
        changed           = trig;
        first_update_next = 1'b0;
      end
      if (fused_presence_next) begin
        fused_presence_next = |(cfg.keep_mask & srcs);
        if (!fused_presence_next) begin
          changed                = 1'b1;
          retrigger_allowed_next = 1'b1;
        end
      end
      if (changed && fused_presence_next) begin
        suppress_flag_next = (32'(cfg.illuminance_threshold) < LIGHT_MAX) &&
                             (item.illuminance > cfg.illuminance_threshold);
      end

      if (!suppress_flag_next && changed) begin
        on_cmd      = fused_presence_next;
        mode_valid  = cfg.onoff_mode inside {MODE_ON_OFF, MODE_ON_ONLY, MODE_OFF_ONLY,
                                             MODE_TIMED_ON, MODE_TIMED_LOCAL};
        cmd_blocked = (on_cmd && cfg.onoff_mode == MODE_OFF_ONLY) ||
                      (!on_cmd && (cfg.onoff_mode inside {MODE_ON_ONLY, MODE_TIMED_ON,
                                                          MODE_TIMED_LOCAL}));
        if (mode_valid && !cmd_blocked && item.targets_bound) begin
          timer_active_next = 1'b0;
          if (cfg.onoff_mode == MODE_TIMED_ON) begin
            cmd = CMD_TIMED;
          end else if (cfg.onoff_mode == MODE_TIMED_LOCAL) begin
            if (cfg.onoff_timeout != 16'd0) begin
              timer_active_next = 1'b1;
              timer_left_next   = cfg.onoff_timeout;
            end
            cmd = CMD_ON;
          end else begin
            cmd = on_cmd ? CMD_ON : CMD_OFF;
          end
        end
      end
    end

    result.presence         = fused_presence_next;
    result.presence_toggle  = changed;
    result.command          = cmd;
    result.suppressed       = suppress_flag_next;
    result.false_pir_count  = false_pulses_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fused_presence    <= 1'b0;
      first_update      <= 1'b1;
      retrigger_allowed <= 1'b0;
      last_radar        <= 1'b0;
      last_pir          <= 1'b0;
      suppress_flag     <= 1'b0;
      pir_probe         <= 1'b0;
      timer_active      <= 1'b0;
      false_pulses      <= 16'd0;
      timer_left        <= 16'd0;
    end else if (fire) begin
      fused_presence    <= fused_presence_next;
      first_update      <= first_update_next;
      retrigger_allowed <= retrigger_allowed_next;
      last_radar        <= last_radar_next;
      last_pir          <= last_pir_next;
      suppress_flag     <= suppress_flag_next;
      pir_probe         <= pir_probe_next;
      timer_active      <= timer_active_next;
      false_pulses      <= false_pulses_next;
      timer_left        <= timer_left_next;
    end
  end

endmodule

// ===== rtl/presence_fusion_onoff_controller_core.sv =====
// Presence fusion on/off controller: top level with input and result registers.
// Each transaction on the input channel is a sensor update or a one-second tick
// and yields exactly one result transaction. A transaction is registered on
// entry, passes through the combinational fusion logic and lands in the result
// register. The block takes one transaction every cycle unless the result side
// stalls; the result register alone sets that rate, and a stalled result holds
// back the input only once the input register is also full. The
// configuration registers should be written only while the block is idle.
module presence_fusion_onoff_controller_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  pfoc_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output pfoc_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [pfoc_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [pfoc_pkg::CfgDataWidth-1:0]   cfg_data
);
  import pfoc_pkg::*;

  cfg_t      cfg;
  in_item_t  hold_item;
  logic      hold_valid;
  logic      advance;
  out_item_t result;

  // The held transaction moves on when the result register is free or draining.
  assign advance  = hold_valid && (!out_valid || !out_stall);
  assign in_stall = hold_valid && !advance;

  pfoc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pfoc_fusion u_fusion (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .fire   (advance),
    .item   (hold_item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (!in_stall) begin
        hold_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_item <= in_data;
    end
    if (advance) begin
      out_data <= result;
    end
  end

endmodule

// ===== tb/presence_fusion_check.sv =====
// Result checker for the presence fusion on/off controller: predicts and compares every result.
`timescale 1ns / 100ps

module presence_fusion_check (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  pfoc_pkg::in_item_t                  in_data,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  pfoc_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [pfoc_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [pfoc_pkg::CfgDataWidth-1:0]   cfg_data,
  output int                                  failures,
  output int                                  awaiting
);
  import pfoc_pkg::*;

  cfg_t        regs;
  logic        fused;
  logic        first_upd;
  logic        retrig_ok;
  logic        last_radar;
  logic        last_pir;
  logic        suppress_on;
  logic        pir_probe;
  logic        timer_on;
  logic [15:0] false_pulses;
  logic [15:0] timer_left;

  out_item_t   expected_results[$];

  task automatic report_mismatch(string msg);
    $display("%0t: %s", $time, msg);
    failures++;
  endtask

  // Picks the command for a presence change; a command that goes out also
  // rearms or stops the local off timer.
  function automatic logic [1:0] choose_command(logic on, logic bound);
    if (regs.onoff_mode == MODE_NOTHING || regs.onoff_mode > MODE_TIMED_LOCAL) return CMD_NONE;
    if (on && regs.onoff_mode == MODE_OFF_ONLY) return CMD_NONE;
    if (!on && (regs.onoff_mode == MODE_ON_ONLY || regs.onoff_mode == MODE_TIMED_ON ||
                regs.onoff_mode == MODE_TIMED_LOCAL)) return CMD_NONE;
    if (!bound) return CMD_NONE;
    timer_on = 1'b0;
    if (regs.onoff_mode == MODE_TIMED_ON) return CMD_TIMED;
    if (regs.onoff_mode == MODE_TIMED_LOCAL) begin
      if (regs.onoff_timeout != 16'd0) begin
        timer_on   = 1'b1;
        timer_left = regs.onoff_timeout;
      end
      return CMD_ON;
    end
    return on ? CMD_ON : CMD_OFF;
  endfunction

  function automatic out_item_t fuse_step(in_item_t it);
    out_item_t  r;
    logic       changed;
    logic       trig;
    logic [1:0] cmd;
    changed = 1'b0;
    cmd     = CMD_NONE;
    if (it.operation == OP_TICK) begin
      if (timer_on) begin
        if (timer_left > 16'd1) begin
          timer_left--;
        end else begin
          timer_left = 16'd0;
          if (fused) begin
            if (regs.onoff_timeout != 16'd0) timer_left = regs.onoff_timeout;
            else timer_on = 1'b0;
          end else begin
            timer_on = 1'b0;
            if (it.targets_bound) cmd = CMD_OFF;
          end
        end
      end
    end else begin
      // A PIR pulse that both starts and ends without radar counts as false.
      if (it.pir_present && !last_pir) begin
        if (!it.mmwave_present) pir_probe = 1'b1;
      end else if (!it.pir_present && last_pir) begin
        if (pir_probe && !it.mmwave_present) begin
          pir_probe = 1'b0;
          if (false_pulses != 16'hFFFF) false_pulses++;
        end
      end
      if (it.mmwave_present) pir_probe = 1'b0;
      last_radar = it.mmwave_present;
      last_pir   = it.pir_present;

      if (first_upd || retrig_ok || !fused) begin
        trig = (regs.edge_mask[0] && last_radar) || (regs.edge_mask[1] && last_pir) ||
               (regs.edge_mask[2] && it.external_present);
        if (trig) begin
          fused     = 1'b1;
          retrig_ok = 1'b0;
        end
        changed   = trig;
        first_upd = 1'b0;
      end
      if (!first_upd && fused) begin
        fused = (regs.keep_mask[0] && last_radar) || (regs.keep_mask[1] && last_pir) ||
                (regs.keep_mask[2] && it.external_present);
        if (!fused) begin
          changed   = 1'b1;
          retrig_ok = 1'b1;
        end
      end
      if (changed && fused)
        suppress_on = (regs.illuminance_threshold < LIGHT_MAX) &&
                      (it.illuminance > regs.illuminance_threshold);
      if (!suppress_on && changed) cmd = choose_command(fused, it.targets_bound);
    end
    r.presence         = fused;
    r.presence_toggle  = changed;
    r.command          = cmd;
    r.suppressed       = suppress_on;
    r.false_pir_count  = false_pulses;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      regs.edge_mask             = 3'd1;
      regs.keep_mask             = 3'd1;
      regs.onoff_mode            = MODE_ON_OFF;
      regs.onoff_timeout         = 16'd0;
      regs.illuminance_threshold = 16'hFFFF;
      fused        = 1'b0;
      first_upd    = 1'b1;
      retrig_ok    = 1'b0;
      last_radar   = 1'b0;
      last_pir     = 1'b0;
      suppress_on  = 1'b0;
      pir_probe    = 1'b0;
      timer_on     = 1'b0;
      false_pulses = 16'd0;
      timer_left   = 16'd0;
      expected_results.delete();
      failures = 0;
    end else begin
      // Results are compared before the new transaction is predicted, so an
      // early result can never be matched against its own input.
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result transaction with no expectation waiting");
        end else begin
          want = expected_results.pop_front();
          if (out_data.presence !== want.presence)
            report_mismatch($sformatf("presence: expected %0d, got %0d",
                                      want.presence, out_data.presence));
          if (out_data.presence_toggle !== want.presence_toggle)
            report_mismatch($sformatf("presence_toggle: expected %0d, got %0d",
                                      want.presence_toggle, out_data.presence_toggle));
          if (out_data.command !== want.command)
            report_mismatch($sformatf("command: expected %0d, got %0d",
                                      want.command, out_data.command));
          if (out_data.suppressed !== want.suppressed)
            report_mismatch($sformatf("suppressed: expected %0d, got %0d",
                                      want.suppressed, out_data.suppressed));
          if (out_data.false_pir_count !== want.false_pir_count)
            report_mismatch($sformatf("false_pir_count: expected %0d, got %0d",
                                      want.false_pir_count, out_data.false_pir_count));
        end
      end
      if (in_valid && !in_stall) expected_results.push_back(fuse_step(in_data));
      if (cfg_we) begin
        case (cfg_index)
          REG_EDGE_MASK:   regs.edge_mask             = cfg_data[2:0];
          REG_KEEP_MASK:   regs.keep_mask             = cfg_data[2:0];
          REG_ONOFF_MODE:  regs.onoff_mode            = cfg_data[2:0];
          REG_ONOFF_TMO:   regs.onoff_timeout         = cfg_data;
          REG_LIGHT_THRES: regs.illuminance_threshold = cfg_data;
          default: ;
        endcase
      end
    end
    awaiting = expected_results.size();
  end

endmodule

// ===== tb/presence_fusion_onoff_controller_core_test.sv =====
// Stimulus and verdict for the presence fusion on/off controller core.
`timescale 1ns / 100ps

module presence_fusion_onoff_controller_core_test;
  import pfoc_pkg::*;

  // Mode values the block treats as doing nothing.
  localparam logic [2:0] MODE_RESERVED_A = 3'd6;
  localparam logic [2:0] MODE_RESERVED_B = 3'd7;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  in_item_t                 in_data = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  out_item_t                out_data;
  logic                     cfg_we = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0]  cfg_data = '0;

  int          failures;
  int          awaiting;
  bit          no_idle = 1'b0;
  int          stall_left = 0;
  logic [2:0]  sens = 3'b000;
  logic [15:0] cur_thr = 16'hFFFF;

  presence_fusion_onoff_controller_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  presence_fusion_check fusion_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .failures  (failures),
    .awaiting  (awaiting)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // The result side stalls in bursts, leaving calm stretches in between.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (!no_idle && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 13);
    end
  end

  function automatic in_item_t sensor_item(logic op, logic mm, logic pir, logic ext,
                                           logic [15:0] light, logic bound);
    return in_item_t'{op, mm, pir, ext, light, bound};
  endfunction

  // Mostly sensor bits that each flip now and then, so that presence is held
  // for a while; now and then a completely fresh set of bits.
  function automatic in_item_t random_item();
    in_item_t it;
    int       roll;
    roll = $urandom_range(0, 99);
    if (roll >= 90) begin
      sens = 3'($urandom_range(0, 7));
    end else if (roll >= 30) begin
      for (int i = 0; i < 3; i++)
        if ($urandom_range(0, 3) == 0) sens[i] = ~sens[i];
    end
    it.operation = (roll < 30) ? OP_TICK : OP_UPDATE;
    {it.mmwave_present, it.pir_present, it.external_present} = sens;
    case ($urandom_range(0, 5))
      0:       it.illuminance = 16'd0;
      1:       it.illuminance = 16'hFFFF;
      2:       it.illuminance = cur_thr;
      3:       it.illuminance = cur_thr + 16'd1;
      default: it.illuminance = 16'($urandom_range(0, 65535));
    endcase
    it.targets_bound = ($urandom_range(0, 6) != 0);
    return it;
  endfunction

  task automatic send(in_item_t it);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic put_reg(logic [CfgIndexWidth-1:0] idx, logic [CfgDataWidth-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic load_config(logic [2:0] edges, logic [2:0] keeps, logic [2:0] mode,
                             logic [15:0] timeout, logic [15:0] thr);
    put_reg(REG_EDGE_MASK, {13'd0, edges});
    put_reg(REG_KEEP_MASK, {13'd0, keeps});
    put_reg(REG_ONOFF_MODE, {13'd0, mode});
    put_reg(REG_ONOFF_TMO, timeout);
    put_reg(REG_LIGHT_THRES, thr);
    cfg_we <= 1'b0;
    cur_thr = thr;
  endtask

  // Waits for every expected result, then lets the block settle.
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int waited;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration: radar starts and holds, plain on/off commands.
    send(sensor_item(OP_UPDATE, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0));
    send(sensor_item(OP_UPDATE, 1'b1, 1'b0, 1'b0, 16'hFFFF, 1'b1));
    send(sensor_item(OP_UPDATE, 1'b0, 1'b0, 1'b0, 16'hFFFF, 1'b1));
    send(sensor_item(OP_UPDATE, 1'b0, 1'b1, 1'b0, 16'd0, 1'b1));
    send(sensor_item(OP_UPDATE, 1'b0, 1'b0, 1'b0, 16'd0, 1'b1));
    send(sensor_item(OP_UPDATE, 1'b0, 1'b1, 1'b0, 16'd0, 1'b1));
    send(sensor_item(OP_UPDATE, 1'b1, 1'b1, 1'b0, 16'd0, 1'b1));
    send(sensor_item(OP_UPDATE, 1'b0, 1'b0, 1'b0, 16'd0, 1'b1));
    send(sensor_item(OP_UPDATE, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0));

    // Local timer: retrigger while held, off command on expiry once clear.
    quiesce();
    load_config(3'b111, 3'b111, MODE_TIMED_LOCAL, 16'd2, 16'd100);
    send(sensor_item(OP_UPDATE, 1'b0, 1'b0, 1'b1, 16'd50, 1'b1));
    send(sensor_item(OP_TICK, 1'b0, 1'b0, 1'b0, 16'd0, 1'b1));
    send(sensor_item(OP_TICK, 1'b0, 1'b0, 1'b0, 16'd0, 1'b1));
    send(sensor_item(OP_UPDATE, 1'b0, 1'b0, 1'b0, 16'd0, 1'b1));
    send(sensor_item(OP_TICK, 1'b0, 1'b0, 1'b0, 16'd0, 1'b1));
    send(sensor_item(OP_TICK, 1'b0, 1'b0, 1'b0, 16'd0, 1'b1));
    send(sensor_item(OP_UPDATE, 1'b0, 1'b0, 1'b1, 16'd200, 1'b1));
    send(sensor_item(OP_UPDATE, 1'b0, 1'b0, 1'b0, 16'd0, 1'b1));

    // External may start but only radar may hold: start and drop at once.
    quiesce();
    load_config(3'b100, 3'b001, MODE_ON_OFF, 16'd1, 16'hFFFF);
    send(sensor_item(OP_UPDATE, 1'b0, 1'b0, 1'b1, 16'd0, 1'b1));
    send(sensor_item(OP_UPDATE, 1'b1, 1'b0, 1'b1, 16'hFFFF, 1'b1));

    quiesce();
    load_config(3'b100, 3'b001, MODE_RESERVED_A, 16'd1, 16'hFFFF);
    send(sensor_item(OP_UPDATE, 1'b0, 1'b0, 1'b0, 16'd0, 1'b1));

    quiesce();
    load_config(3'b100, 3'b001, MODE_TIMED_LOCAL, 16'd1, 16'hFFFF);
    send(sensor_item(OP_UPDATE, 1'b1, 1'b0, 1'b1, 16'd0, 1'b1));
    send(sensor_item(OP_TICK, 1'b0, 1'b0, 1'b0, 16'd0, 1'b1));

    quiesce();
    load_config(3'b100, 3'b001, MODE_OFF_ONLY, 16'd0, 16'hFFFF);
    send(sensor_item(OP_UPDATE, 1'b0, 1'b0, 1'b0, 16'd0, 1'b1));
    send(sensor_item(OP_UPDATE, 1'b1, 1'b0, 1'b1, 16'd0, 1'b1));

    quiesce();
    load_config(3'b100, 3'b001, MODE_TIMED_ON, 16'd0, 16'hFFFE);
    send(sensor_item(OP_UPDATE, 1'b0, 1'b0, 1'b0, 16'd0, 1'b1));
    send(sensor_item(OP_UPDATE, 1'b1, 1'b0, 1'b1, 16'hFFFE, 1'b1));

    // Random phases, the first three at the extremes of the registers.
    for (int phase = 0; phase < 7; phase++) begin
      quiesce();
      case (phase)
        0: load_config(3'b111, 3'b111, MODE_TIMED_LOCAL, 16'd3, 16'hFFFF);
        1: load_config(3'b000, 3'b000, MODE_NOTHING, 16'd0, 16'd0);
        2: load_config(3'b111, 3'b111, MODE_RESERVED_B, 16'hFFFF, 16'hFFFE);
        default:
          load_config(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                      3'($urandom_range(0, 7)),
                      ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom_range(1, 4)),
                      ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535)));
      endcase
      repeat (64) send(random_item());
    end

    // A last stretch at full rate of PIR pulses that radar never sees.
    quiesce();
    no_idle = 1'b1;
    load_config(3'b000, 3'b000, MODE_NOTHING, 16'd0, 16'hFFFF);
    repeat (20) begin
      send(sensor_item(OP_UPDATE, 1'b0, 1'b1, 1'b0, 16'd0, 1'b1));
      send(sensor_item(OP_UPDATE, 1'b0, 1'b0, 1'b0, 16'd0, 1'b1));
    end

    in_valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (awaiting != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (failures == 0 && awaiting == 0)
      $display("presence_fusion_onoff_controller_core_test passed");
    else
      $display("presence_fusion_onoff_controller_core_test failed");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("presence_fusion_onoff_controller_core_test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pfoc_pkg.sv
rtl/pfoc_cfg_regs.sv
rtl/pfoc_fusion.sv
rtl/presence_fusion_onoff_controller_core.sv
tb/presence_fusion_check.sv
tb/presence_fusion_onoff_controller_core_test.sv
